[rtl/sba_pkg.sv]
// Package for the spike burst analyzer: shared types, constants and the
// controller state encoding. No dependencies.
`default_nettype none
package sba_pkg;
	localparam int REG_THRESHOLD = 0;
	localparam int REG_BURST_GAP = 1;
	localparam logic [15:0] THRESHOLD_RESET = 16'hF600;
	localparam logic [15:0] BURST_GAP_RESET = 16'd400;
	localparam logic [15:0] PEAK_RESET = 16'h9C00;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [23:0] RATE_MAX = 24'hFFFFFF;
	localparam int RECIP_SUM_WIDTH = 40;
	localparam logic KIND_SPIKE = 1'b0;
	localparam logic KIND_BURST = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GAP,
		ST_RECIP,
		ST_RECIP_ADD,
		ST_RATE,
		ST_DUTY,
		ST_EMIT_SPIKE,
		ST_EMIT_BURST
	} state_t;

	// start/busy handshake between controller and the bit-serial divider
	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;
endpackage
`default_nettype wire

[rtl/sba_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on sba_pkg for the control struct.
`default_nettype none
module sba_divider #(
	parameter int NUM_WIDTH = 64,
	parameter int DEN_WIDTH = 48
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [NUM_WIDTH-1:0] numer,
	input  wire logic [DEN_WIDTH-1:0] denom,
	output sba_pkg::div_ctl_t         ctl,
	output logic      [NUM_WIDTH-1:0] quot
);
	localparam int CW = $clog2(NUM_WIDTH + 1);
	logic [NUM_WIDTH-1:0] num_q;
	logic [DEN_WIDTH:0]   rem_q;
	logic [DEN_WIDTH-1:0] den_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic [DEN_WIDTH:0]   trial;
	logic [DEN_WIDTH:0]   shifted;

	assign shifted = {rem_q[DEN_WIDTH-1:0], num_q[NUM_WIDTH-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(NUM_WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[DEN_WIDTH]) begin
				rem_q <= trial;
				num_q <= {num_q[NUM_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				num_q <= {num_q[NUM_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign quot = num_q;
	assign ctl.start = start;
	assign ctl.busy = busy_q;
endmodule
`default_nettype wire

[rtl/spike_burst_analyzer.sv]
// Top level of the spike burst analyzer: spike detection, burst bookkeeping
// and the controller that drives a shared bit-serial divider.
// Depends on sba_pkg and sba_divider.
// A sample that ends no spike is taken every cycle while no result waits to be
// sent. The divider is DW = COUNT_WIDTH + RECIP_FRAC + 1 (57) bits wide. A spike
// that needs no division goes straight to bookkeeping, a spike inside a burst first
// divides for the reciprocal of the gap, and a spike closing a burst divides for the
// rate, then the duty cycle; the result stream can stall each. One item at a time.
// Reset (arst_n low): clears all detection state, loads register defaults.
`default_nettype none
module spike_burst_analyzer #(
	parameter int COUNT_WIDTH  = 32,
	parameter int SAMPLE_WIDTH = 16,
	parameter int RECIP_FRAC   = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata: sample (signed); zero-filled to bytes
	input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	input  wire logic        s_tlast,  // end_of_record
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: spike_index[31:0], burst_start, burst_period, burst_duration,
	// interburst_gap (32 each), spike_count[15:0], spike_rate[23:0],
	// duty_cycle[15:0]; 216 bits
	output logic [215:0]     m_tdata,
	output logic             m_tuser,  // kind
	output logic             m_tlast,  // last_result
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam int DW = COUNT_WIDTH + RECIP_FRAC + 1;
	localparam int RW = sba_pkg::RECIP_SUM_WIDTH;

	logic [15:0] thr_q, gap_set_q;
	logic armed_q, above_q, have_prev_q, open_q;
	logic [COUNT_WIDTH-1:0] count_q, peak_idx_q, prev_q, start_q;
	logic signed [SAMPLE_WIDTH-1:0] peak_val_q;
	logic [15:0] spikes_q;
	logic [RW-1:0] recip_q;
	sba_pkg::state_t state_q, state_d;
	// spike being processed
	logic [COUNT_WIDTH-1:0] idx_q, gap_q, per_q, dur_q;
	logic eor_q, close_q;
	logic [23:0] rate_q;
	logic [15:0] duty_q;
	// output register
	logic ovalid_q;

	logic signed [SAMPLE_WIDTH-1:0] smp;
	logic signed [SAMPLE_WIDTH:0] thr_ext;
	logic acc, gt, spike;
	logic [COUNT_WIDTH-1:0] pidx;
	logic div_go;
	logic [DW-1:0] d_num, d_quot;
	logic [COUNT_WIDTH-1:0] d_den;
	sba_pkg::div_ctl_t dctl;
	logic [RW:0] recip_sum_w;

	assign smp = s_tdata[SAMPLE_WIDTH-1:0];
	assign thr_ext = (SAMPLE_WIDTH+1)'(signed'(thr_q));
	assign gt = (SAMPLE_WIDTH+1)'(smp) > thr_ext;
	assign s_tready = (state_q == sba_pkg::ST_IDLE) && !ovalid_q;
	assign acc = s_tvalid && s_tready;
	// spike ends at a sample at or below threshold, or at end of record; a run that
	// starts on the final sample is a spike of its own
	assign spike = (above_q && !gt) || (s_tlast && (above_q || (gt && armed_q)));
	// peak of the run including the current sample
	assign pidx = (gt && armed_q && (!above_q || smp > peak_val_q)) ? count_q : peak_idx_q;

	sba_divider #(.NUM_WIDTH(DW), .DEN_WIDTH(COUNT_WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .numer(d_num), .denom(d_den),
		.ctl(dctl), .quot(d_quot)
	);

	// divider operand select
	always_comb begin
		d_num = '0;
		d_den = COUNT_WIDTH'(1);
		div_go = 1'b0;
		unique case (state_q)
			sba_pkg::ST_GAP: begin
				div_go = 1'b1;
				if (close_q) begin
					d_num = DW'(recip_q);
					d_den = (spikes_q > 16'd1) ? COUNT_WIDTH'(spikes_q - 16'd1)
						: COUNT_WIDTH'(1);
				end else begin
					d_num = DW'(1) << RECIP_FRAC;
					d_den = (gap_q == '0) ? COUNT_WIDTH'(1) : gap_q;
				end
			end
			sba_pkg::ST_RATE: begin
				div_go = !dctl.busy;
				d_num = DW'(dur_q) << 16;
				d_den = (per_q == '0) ? COUNT_WIDTH'(1) : per_q;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sba_pkg::ST_IDLE: if (acc && spike) state_d = sba_pkg::ST_EMIT_SPIKE;
			sba_pkg::ST_EMIT_SPIKE: if (!ovalid_q) begin
				if (close_q || (open_q && have_prev_q && spikes_q < sba_pkg::COUNT_MAX))
					state_d = sba_pkg::ST_GAP;
				else
					state_d = sba_pkg::ST_DUTY;
			end
			sba_pkg::ST_GAP: state_d = close_q ? sba_pkg::ST_RECIP : sba_pkg::ST_RECIP_ADD;
			sba_pkg::ST_RECIP: if (!dctl.busy) state_d = sba_pkg::ST_RATE;
			sba_pkg::ST_RATE: state_d = sba_pkg::ST_RECIP_ADD;
			sba_pkg::ST_RECIP_ADD: if (!dctl.busy)
				state_d = close_q ? sba_pkg::ST_EMIT_BURST : sba_pkg::ST_DUTY;
			sba_pkg::ST_EMIT_BURST: if (!ovalid_q) state_d = sba_pkg::ST_DUTY;
			sba_pkg::ST_DUTY: state_d = sba_pkg::ST_IDLE;
			default: state_d = sba_pkg::ST_IDLE;
		endcase
	end

	assign recip_sum_w = {1'b0, recip_q} + (RW+1)'(d_quot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= sba_pkg::THRESHOLD_RESET;
			gap_set_q <= sba_pkg::BURST_GAP_RESET;
			state_q <= sba_pkg::ST_IDLE;
			armed_q <= 1'b0; above_q <= 1'b0; have_prev_q <= 1'b0; open_q <= 1'b0;
			count_q <= '0; peak_idx_q <= '0; prev_q <= '0; start_q <= '0;
			peak_val_q <= SAMPLE_WIDTH'(signed'(sba_pkg::PEAK_RESET));
			spikes_q <= '0; recip_q <= '0;
			idx_q <= '0; gap_q <= '0; per_q <= '0; dur_q <= '0;
			rate_q <= '0; duty_q <= '0;
			ovalid_q <= 1'b0; eor_q <= 1'b0; close_q <= 1'b0;
			m_tuser <= sba_pkg::KIND_SPIKE; m_tlast <= 1'b0; m_tdata <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'(sba_pkg::REG_THRESHOLD)) thr_q <= cfg_data;
				else if (cfg_index == 1'(sba_pkg::REG_BURST_GAP)) gap_set_q <= cfg_data;
			end
			state_q <= state_d;
			if (ovalid_q && m_tready) ovalid_q <= 1'b0;
			if (acc) begin
				// restart the sample index and disarm after the final sample
				count_q <= s_tlast ? '0 : count_q + 1'b1;
				armed_q <= s_tlast ? 1'b0 : (armed_q || !gt);
				above_q <= gt && armed_q && !s_tlast;
				if (gt && armed_q && (!above_q || smp > peak_val_q)) begin
					peak_val_q <= smp; peak_idx_q <= count_q;
				end
				eor_q <= s_tlast;
				if (spike) begin
					idx_q <= pidx;
					gap_q <= pidx - prev_q;
					per_q <= pidx - start_q;
					dur_q <= prev_q - start_q;
					close_q <= have_prev_q && open_q && (pidx - prev_q > COUNT_WIDTH'(gap_set_q));
				end else if (s_tlast) begin
					have_prev_q <= 1'b0; open_q <= 1'b0;
					prev_q <= '0; start_q <= '0; spikes_q <= '0; recip_q <= '0;
				end
			end
			unique case (state_q)
				sba_pkg::ST_EMIT_SPIKE: if (!ovalid_q) begin
					ovalid_q <= 1'b1;
					m_tuser <= sba_pkg::KIND_SPIKE;
					m_tdata <= {184'd0, 32'(idx_q)};
					m_tlast <= !close_q;
				end
				sba_pkg::ST_RECIP: if (!dctl.busy && !dctl.start)
					rate_q <= (spikes_q > 16'd1)
						? ((|d_quot[DW-1:24]) ? sba_pkg::RATE_MAX : d_quot[23:0]) : '0;
				sba_pkg::ST_RECIP_ADD: if (!dctl.busy && !dctl.start) begin
					if (close_q)
						duty_q <= (per_q == '0) ? 16'd0
							: (dur_q >= per_q) ? 16'hFFFF : d_quot[15:0];
					else begin
						spikes_q <= spikes_q + 1'b1;
						recip_q <= recip_sum_w[RW] ? {RW{1'b1}} : recip_sum_w[RW-1:0];
					end
				end
				sba_pkg::ST_EMIT_BURST: if (!ovalid_q) begin
					ovalid_q <= 1'b1;
					m_tuser <= sba_pkg::KIND_BURST;
					m_tlast <= 1'b1;
					m_tdata <= {duty_q, rate_q, spikes_q, 32'(gap_q), 32'(dur_q),
						32'(per_q), 32'(start_q), 32'd0};
				end
				sba_pkg::ST_DUTY: begin
					// commit burst bookkeeping, or clear it on end of record
					close_q <= 1'b0;
					if (eor_q) begin
						have_prev_q <= 1'b0; open_q <= 1'b0; prev_q <= '0; start_q <= '0;
						spikes_q <= '0; recip_q <= '0;
					end else begin
						if (have_prev_q ? (gap_q > COUNT_WIDTH'(gap_set_q))
								: (idx_q > COUNT_WIDTH'(gap_set_q))) begin
							open_q <= 1'b1; start_q <= idx_q; spikes_q <= 16'd1;
							recip_q <= '0;
						end
						have_prev_q <= 1'b1;
						prev_q <= idx_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = ovalid_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sba_pkg::ST_IDLE) |-> !s_tready) else $error("accept while busy");
	a_burst_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast) else $error("burst not last");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> !dctl.busy) else $error("divider restarted");
endmodule
`default_nettype wire

[bench/spike_burst_analyzer_tb.sv]
// Self-checking bench for spike_burst_analyzer: drives voltage records over the
// input stream, predicts spike events and burst records in-line, and checks the
// result stream field by field. Depends on sba_pkg and the analyzer RTL.
`timescale 1ns / 1ps
module spike_burst_analyzer_tb;

	localparam int QUIET_LIMIT = 6000;  // cycles with no handshake before giving up
	localparam int DRAIN_CYCLES = 400;  // covers the slowest burst close
	localparam logic [15:0] PEAK_RESET = 16'h9C00;  // -100 mV in Q8.8

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic [15:0] sample;
		logic eor;
	} voltage_item_t;

	typedef struct {
		logic kind;
		logic [31:0] spike_index;
		logic [31:0] burst_start;
		logic [31:0] burst_period;
		logic [31:0] burst_duration;
		logic [31:0] interburst_gap;
		logic [15:0] spike_count;
		logic [23:0] spike_rate;
		logic [15:0] duty_cycle;
		logic last;
	} event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;  // sample (signed)
	logic s_tlast = 1'b0;  // end_of_record
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [215:0] m_tdata;  // spike_index, burst_start, period, duration, gap, count, rate, duty
	logic m_tuser;  // kind
	logic m_tlast;  // last_result
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	spike_burst_analyzer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	voltage_item_t pending_samples[$];
	event_t expected_events[$];
	idle_mode_t idle_mode = IDLE_NONE;
	int errors = 0;
	int quiet_cycles = 0;

	// Predictor copy of the registers and the detection state.
	logic signed [15:0] thr_q88;
	logic [15:0] gap_setting;
	logic armed, above, have_prev, burst_open;
	logic [31:0] sample_count, peak_index, prev_index, burst_start_idx;
	logic signed [15:0] peak_value;
	logic [15:0] burst_spikes;
	logic [40:0] recip_sum;

	function automatic void clear_detector();
		armed = 0;
		above = 0;
		sample_count = 0;
		peak_value = PEAK_RESET;
		peak_index = 0;
		have_prev = 0;
		prev_index = 0;
		burst_open = 0;
		burst_start_idx = 0;
		burst_spikes = 0;
		recip_sum = 0;
	endfunction

	function automatic void open_burst(logic [31:0] idx);
		burst_open = 1;
		burst_start_idx = idx;
		burst_spikes = 1;
		recip_sum = 0;
	endfunction

	// Spike bookkeeping: always a spike event, plus a burst record when a long
	// gap closes an open burst.
	function automatic void log_spike(logic [31:0] idx);
		event_t ev;
		logic [31:0] gap, per, dur, d;
		logic [40:0] rate;
		logic [47:0] num;
		ev = '{default: '0};
		ev.kind = sba_pkg::KIND_SPIKE;
		ev.spike_index = idx;
		expected_events.push_back(ev);
		if (!have_prev) begin
			if (idx > {16'b0, gap_setting}) open_burst(idx);
		end else begin
			gap = idx - prev_index;
			if (gap > {16'b0, gap_setting}) begin
				if (burst_open) begin
					per = idx - burst_start_idx;
					dur = prev_index - burst_start_idx;
					rate = 0;
					if (burst_spikes > 1) begin
						rate = recip_sum / (burst_spikes - 16'd1);
						if (rate > sba_pkg::RATE_MAX) rate = sba_pkg::RATE_MAX;
					end
					ev = '{default: '0};
					ev.kind = sba_pkg::KIND_BURST;
					ev.burst_start = burst_start_idx;
					ev.burst_period = per;
					ev.burst_duration = dur;
					ev.interburst_gap = gap;
					ev.spike_count = burst_spikes;
					ev.spike_rate = rate[23:0];
					if (per == 0) ev.duty_cycle = 0;
					else if (dur >= per) ev.duty_cycle = 16'hFFFF;
					else begin
						num = {dur, 16'b0};
						ev.duty_cycle = 16'(num / per);
					end
					expected_events.push_back(ev);
				end
				open_burst(idx);
			end else if (burst_open && burst_spikes < sba_pkg::COUNT_MAX) begin
				d = (gap == 0) ? 32'd1 : gap;
				burst_spikes++;
				recip_sum += (41'd1 << 24) / d;
				if (recip_sum > {1'b0, {40{1'b1}}}) recip_sum = {1'b0, {40{1'b1}}};
			end
		end
		have_prev = 1;
		prev_index = idx;
	endfunction

	function automatic void predict_sample(logic signed [15:0] s, logic eor);
		int before_n;
		logic spike;
		before_n = expected_events.size();
		spike = 0;
		if (s > thr_q88) begin
			if (armed) begin
				if (!above) begin
					above = 1;
					peak_value = s;
					peak_index = sample_count;
				end else if (s > peak_value) begin
					peak_value = s;
					peak_index = sample_count;
				end
			end
		end else begin
			armed = 1;
			if (above) begin
				above = 0;
				spike = 1;
			end
		end
		if (eor && above) begin
			above = 0;
			spike = 1;
		end
		if (spike) log_spike(peak_index);
		sample_count++;
		if (eor) clear_detector();
		if (expected_events.size() > before_n)
			expected_events[expected_events.size() - 1].last = 1;
	endfunction

	function automatic bit roll_idle(bit is_sender);
		case (idle_mode)
			IDLE_SENDER: return is_sender && $urandom_range(99) < 82;
			IDLE_RECEIVER: return !is_sender && $urandom_range(99) < 82;
			IDLE_BOTH: return $urandom_range(99) < 10;
			default: return 0;
		endcase
	endfunction

	// Driver: advance to the next pending item once the current one is taken,
	// predict each item at its handshake.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) predict_sample(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (pending_samples.size() > 0 && !roll_idle(1)) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_samples[0].sample;
					s_tlast <= pending_samples[0].eor;
					void'(pending_samples.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Monitor: compare each result item against the oldest expectation.
	always @(posedge clk) begin
		event_t ev;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					$error("result item with nothing expected (kind %0b)", m_tuser);
					errors++;
				end else begin
					ev = expected_events.pop_front();
					check_field("kind", ev.kind, m_tuser);
					check_field("spike_index", ev.spike_index, m_tdata[31:0]);
					check_field("burst_start", ev.burst_start, m_tdata[63:32]);
					check_field("burst_period", ev.burst_period, m_tdata[95:64]);
					check_field("burst_duration", ev.burst_duration, m_tdata[127:96]);
					check_field("interburst_gap", ev.interburst_gap, m_tdata[159:128]);
					check_field("spike_count", ev.spike_count, m_tdata[175:160]);
					check_field("spike_rate", ev.spike_rate, m_tdata[199:176]);
					check_field("duty_cycle", ev.duty_cycle, m_tdata[215:200]);
					check_field("last_result", ev.last, m_tlast);
				end
			end
			m_tready <= !roll_idle(0);
		end
	end

	// Watchdog on handshake activity.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == sba_pkg::REG_THRESHOLD) thr_q88 = value;
		else gap_setting = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_sample(int s, bit eor);
		voltage_item_t it;
		it.sample = 16'(s);
		it.eor = eor;
		pending_samples.push_back(it);
	endtask

	function automatic int pick(int lo, int hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// Hold until the block has delivered everything, then let it settle.
	task automatic drain();
		while (pending_samples.size() > 0 || s_tvalid || expected_events.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One record: mostly baseline and spike runs shaped around the gap setting,
	// with some noise, an optional above-threshold lead-in, eor on the last item.
	task automatic gen_record(int n);
		int t, made, len, v, cap;
		bit can_spike;
		t = thr_q88;
		can_spike = t < 32767;
		made = 0;
		cap = (gap_setting < 60) ? gap_setting + 6 : 6;
		if (can_spike && $urandom_range(2) == 0) begin
			repeat (pick(1, 3)) begin
				push_sample(pick(t + 1, 32767), 0);
				made++;
			end
		end
		while (made < n) begin
			if ($urandom_range(9) == 0) begin
				push_sample($urandom_range(65535), 0);
				made++;
			end else begin
				if ($urandom_range(2) == 0) len = (gap_setting < 60) ?
						pick(gap_setting, cap) : pick(1, cap);
				else len = pick(1, (gap_setting < 6) ? gap_setting + 1 : 6);
				repeat (len) push_sample(pick(-32768, t), 0);
				made += len;
				if (can_spike) begin
					len = pick(1, 4);
					v = pick(t + 1, 32767);
					repeat (len) begin
						// equal peaks now and then
						if ($urandom_range(3) != 0) v = pick(t + 1, 32767);
						push_sample(v, 0);
					end
					made += len;
				end
			end
		end
		pending_samples[pending_samples.size() - 1].eor = 1;
	endtask

	initial begin
		int thr_tab[8] = '{0, -32768, 32767, 256, -2560, -1, 32766, 1000};
		int gap_tab[8] = '{1, 2, 65535, 5, 12, 3, 7, 400};
		int phase_items;
		thr_q88 = sba_pkg::THRESHOLD_RESET;
		gap_setting = sba_pkg::BURST_GAP_RESET;
		clear_detector();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at reset settings: lead-in above threshold, a sample equal
		// to threshold, equal peaks, record ending inside a spike, field extremes.
		push_sample(0, 0);
		push_sample(100, 0);
		push_sample(-5000, 0);
		push_sample(-2560, 0);
		push_sample(256, 0);
		push_sample(512, 0);
		push_sample(512, 0);
		push_sample(-3000, 0);
		push_sample(1000, 0);
		push_sample(1000, 1);
		push_sample(-32768, 0);
		push_sample(32767, 0);
		push_sample(-32768, 0);
		push_sample(32767, 0);
		push_sample(-2559, 0);
		push_sample(-2561, 0);
		push_sample(-2559, 1);
		push_sample(-32768, 1);
		push_sample(32767, 1);
		drain();

		// Random phases over register settings and idling patterns; every phase
		// boundary makes the sender pause until all results have come.
		for (int p = 0; p < 8; p++) begin
			idle_mode = idle_mode_t'(p % 4);
			write_reg(sba_pkg::REG_THRESHOLD, 16'(thr_tab[p]));
			write_reg(sba_pkg::REG_BURST_GAP, 16'(gap_tab[p]));
			phase_items = 0;
			while (phase_items < 150) begin
				gen_record(pick(20, 120));
				phase_items = pending_samples.size() + phase_items;
				while (pending_samples.size() > 0) @(posedge clk);
			end
			drain();
		end

		if (errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
